@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top level of the quantizer.
// No dependencies; the including module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define MMSQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked outside reset.
`define MMSQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/core/mmsq_pkg.sv @@
// Shared types and constants of the min/max scalar quantizer.
// No dependencies; used by mmsq_lane and the top level.
`default_nettype none
package mmsq_pkg;
	localparam int LANES_DEF    = 8;
	localparam int SAMPLE_W_DEF = 32;
	localparam int PORT_W       = 32;
	localparam int STEP_W       = 29;
	localparam int CODE_W       = 4;
	localparam int IDX_W        = 3;
	localparam int CMD_W        = 2;
	localparam int CNT_W        = 6;
	localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(65536);

	localparam logic [CMD_W-1:0] CMD_GATHER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BOUNDS = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd2;

	localparam logic KIND_BOUND = 1'b0;
	localparam logic KIND_CODE  = 1'b1;

	typedef struct packed {
		logic gather;
		logic restart;
		logic div_start;
		logic enc_start;
		logic step_en;
	} lane_ctrl_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DIV   = 5'b00010,
		S_ENC   = 5'b00100,
		S_BOUND = 5'b01000,
		S_CODE  = 5'b10000
	} state_t;
endpackage
`default_nettype wire

@@ rtl/core/mmsq_lane.sv @@
// One quantizer lane: min/max tracking, a two-step divide by 15 for the step,
// and a 4-step successive approximation for the code. Depends on mmsq_pkg.
`default_nettype none
module mmsq_lane #(
	parameter int SAMPLE_WIDTH = mmsq_pkg::SAMPLE_W_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  mmsq_pkg::lane_ctrl_t                   ctrl,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    x,
	output logic signed [SAMPLE_WIDTH-1:0]         lower,
	output logic [mmsq_pkg::STEP_W-1:0]            step,
	output logic [mmsq_pkg::CODE_W-1:0]            code
);
	import mmsq_pkg::*;

	localparam int RW = SAMPLE_WIDTH + 1;
	localparam int DW = SAMPLE_WIDTH + 2;
	localparam int TW = RW + 5;
	localparam int XW = 34;

	logic signed [SAMPLE_WIDTH-1:0] min_q, max_q;
	logic [RW-1:0]       rng;
	logic                rng_zero;
	logic [XW-1:0]       dnum;
	logic [31:0]         dp_q, dp2_q, quo_q;
	logic [18:0]         dm_q;
	logic [16:0]         dv_q;
	logic [34:0]         dv_prod;
	logic signed [DW-1:0] d;
	logic [RW-1:0]       dm;
	logic [TW-1:0]       t_val, t_q, prod;
	logic                zero_q;
	logic [CODE_W-1:0]   c_q, m_q, cand;
	logic [4:0]          odd;

	assign rng      = RW'({max_q[SAMPLE_WIDTH-1], max_q} - {min_q[SAMPLE_WIDTH-1], min_q});
	assign rng_zero = (rng == '0);

	assign dnum    = XW'(rng) + XW'(7);
	// 139811 = ceil(2^21 / 15), exact for values below 2^17
	assign dv_prod = 35'(dv_q) * 35'(139811);

	assign d     = DW'(x) - DW'(min_q);
	assign dm    = d[RW-1:0];
	assign t_val = TW'({dm, 5'b0}) - TW'({dm, 1'b0});

	assign cand = c_q | m_q;
	assign odd  = {cand, 1'b0} - 5'd1;
	assign prod = TW'(odd) * TW'(rng);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '0;
		end else if (ctrl.gather) begin
			if (ctrl.restart || x < min_q) min_q <= x;
			if (ctrl.restart || x > max_q) max_q <= x;
		end
	end

	// divide (range + 7) by 15: 2^16 = 15*4369 + 1, so each high half
	// contributes 4369 per unit to the quotient and folds into the low half
	always_ff @(posedge clk) begin
		if (ctrl.div_start) begin
			dp_q <= 32'(dnum[XW-1:16]) * 32'(4369);
			dm_q <= 19'(dnum[XW-1:16]) + 19'(dnum[15:0]);
		end else if (ctrl.step_en) begin
			dp2_q <= dp_q + 32'(dm_q[18:16]) * 32'(4369);
			dv_q  <= 17'(dm_q[18:16]) + 17'(dm_q[15:0]);
			quo_q <= dp2_q + 32'(dv_prod[34:21]);
		end
	end

	// code >= c iff (2c-1)*range <= 30*(x-lower)
	always_ff @(posedge clk) begin
		if (ctrl.enc_start) begin
			t_q    <= t_val;
			zero_q <= d[DW-1] | rng_zero;
			c_q    <= '0;
			m_q    <= 4'b1000;
		end else if (ctrl.step_en) begin
			if (m_q != '0 && prod <= t_q) c_q <= cand;
			m_q <= m_q >> 1;
		end
	end

	assign lower = min_q;
	assign step  = rng_zero ? STEP_ONE : STEP_W'(quo_q);
	assign code  = zero_q ? '0 : c_q;
endmodule
`default_nettype wire

@@ rtl/core/minmax_scalar_quantizer_4bit.sv @@
// Sequence: gather updates the bounds when the word is taken; encode steps
// through S_ENC, then S_CODE loads the code word; bounds runs the 2-step
// divide by 15 in S_DIV, then S_BOUND loads the 8 lane words, one per cycle
// while the output is free. Throughput: one input word at a time; gather
// every cycle while idle; no new word until the last result word is loaded.
// Reset (arst_n low, async): bounds and seen flag clear, output empty.
`default_nettype none
`include "assert_macros.svh"
module minmax_scalar_quantizer_4bit #(
	parameter int LANES        = mmsq_pkg::LANES_DEF,
	parameter int SAMPLE_WIDTH = mmsq_pkg::SAMPLE_W_DEF
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     item_valid,
	output logic                                    item_ready,
	input  wire logic [mmsq_pkg::CMD_W-1:0]         cmd,
	input  wire                                     first,
	input  wire logic signed [mmsq_pkg::PORT_W-1:0] lane0,
	input  wire logic signed [mmsq_pkg::PORT_W-1:0] lane1,
	input  wire logic signed [mmsq_pkg::PORT_W-1:0] lane2,
	input  wire logic signed [mmsq_pkg::PORT_W-1:0] lane3,
	input  wire logic signed [mmsq_pkg::PORT_W-1:0] lane4,
	input  wire logic signed [mmsq_pkg::PORT_W-1:0] lane5,
	input  wire logic signed [mmsq_pkg::PORT_W-1:0] lane6,
	input  wire logic signed [mmsq_pkg::PORT_W-1:0] lane7,
	output logic                                    result_valid,
	input  wire                                     result_ready,
	output logic                                    kind,
	output logic [mmsq_pkg::PORT_W-1:0]             code_word,
	output logic [mmsq_pkg::IDX_W-1:0]              lane_index,
	output logic signed [mmsq_pkg::PORT_W-1:0]      lane_lower,
	output logic [mmsq_pkg::STEP_W-1:0]             lane_step,
	output logic                                    last
);
	import mmsq_pkg::*;

	localparam int DIV_STEPS = 2;
	localparam int ENC_STEPS = CODE_W;

	logic [PORT_W-1:0] lane_in [8];
	logic signed [SAMPLE_WIDTH-1:0] low_l  [LANES];
	logic [STEP_W-1:0]              step_l [LANES];
	logic [CODE_W-1:0]              code_l [LANES];

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic              seen_q;
	logic              accept, slot_free, idx_last, load_out;
	lane_ctrl_t        ctrl;
	logic [PORT_W-1:0] word;

	assign lane_in[0] = lane0;
	assign lane_in[1] = lane1;
	assign lane_in[2] = lane2;
	assign lane_in[3] = lane3;
	assign lane_in[4] = lane4;
	assign lane_in[5] = lane5;
	assign lane_in[6] = lane6;
	assign lane_in[7] = lane7;

	// Take a new word only when no work is in flight.
	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	// Output register is free when empty or being drained this cycle.
	assign slot_free  = !result_valid || result_ready;
	assign idx_last   = (idx_q == IDX_W'(LANES - 1));
	// Load a result word whenever one is ready and the slot is free.
	assign load_out   = slot_free && ((state_q == S_BOUND) || (state_q == S_CODE));

	// Control goes to all lanes; first or no sample yet restarts tracking.
	always_comb begin
		ctrl.gather    = accept && (cmd == CMD_GATHER);
		ctrl.restart   = first || !seen_q;
		ctrl.div_start = accept && (cmd == CMD_BOUNDS);
		ctrl.enc_start = accept && (cmd == CMD_ENCODE);
		ctrl.step_en   = (state_q == S_DIV) || (state_q == S_ENC);
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		mmsq_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.x      (lane_in[i][SAMPLE_WIDTH-1:0]),
			.lower  (low_l[i]),
			.step   (step_l[i]),
			.code   (code_l[i])
		);
	end

	// Merge: pack lane codes, lanes at or above LANES stay zero.
	always_comb begin
		word = '0;
		for (int i = 0; i < LANES; i++) begin
			word[CODE_W*i +: CODE_W] = code_l[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			seen_q       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_GATHER: seen_q <= 1'b1;
							CMD_BOUNDS: begin
								state_q <= S_DIV;
								cnt_q   <= CNT_W'(DIV_STEPS);
							end
							CMD_ENCODE: begin
								state_q <= S_ENC;
								cnt_q   <= CNT_W'(ENC_STEPS);
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_BOUND;
						idx_q   <= '0;
					end
				end
				S_ENC: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) state_q <= S_CODE;
				end
				S_BOUND: begin
					if (slot_free) begin
						idx_q <= idx_q + 1'b1;
						if (idx_last) state_q <= S_IDLE;
					end
				end
				S_CODE: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// Raise valid on a load, drop it once the word is taken.
			if (load_out) result_valid <= 1'b1;
			else if (result_ready) result_valid <= 1'b0;
		end
	end

	// Output payload: load together with result_valid, hold otherwise.
	always_ff @(posedge clk) begin
		if (state_q == S_BOUND && slot_free) begin
			kind       <= KIND_BOUND;
			code_word  <= '0;
			lane_index <= idx_q;
			lane_lower <= PORT_W'(low_l[idx_q]);
			lane_step  <= step_l[idx_q];
			last       <= idx_last;
		end else if (state_q == S_CODE && slot_free) begin
			kind       <= KIND_CODE;
			code_word  <= word;
			lane_index <= '0;
			lane_lower <= '0;
			lane_step  <= '0;
			last       <= 1'b1;
		end
	end

	`MMSQ_ASSERT_NEXT(a_bounds_start, accept && cmd == CMD_BOUNDS, state_q == S_DIV, "bounds did not start divide")
	`MMSQ_ASSERT_NEXT(a_bounds_end, state_q == S_BOUND && slot_free && idx_last, state_q == S_IDLE && result_valid && last, "last lane word not flagged")
	`MMSQ_ASSERT_NOW(a_code_last, result_valid && kind == KIND_CODE, last, "code word without last")
endmodule
`default_nettype wire
